// ===== design/strf_pkg.sv =====
// Package for the steering torque ramp and frame block.
// Holds the channel payload types and the frame constants; no dependencies.
`timescale 1ns / 1ps

package strf_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 13;

  // Register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_MAX_STEP     = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_BOUND_MARGIN = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_BOUND_LIMIT  = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_RATE_WINDOW  = 2'd3;

  // Register reset values.
  localparam logic [5:0]  MAX_STEP_RESET     = 6'd6;
  localparam logic [11:0] BOUND_MARGIN_RESET = 12'd300;
  localparam logic [12:0] BOUND_LIMIT_RESET  = 13'd1450;
  localparam logic [11:0] RATE_WINDOW_RESET  = 12'd200;

  // Frame length plus both identifier bytes, folded into the checksum seed.
  localparam logic [7:0] FRAME_LEN      = 8'd5;
  localparam logic [15:0] FRAME_ID      = 16'h02e4;
  localparam logic [7:0] CHECKSUM_SEED  = 8'(FRAME_LEN + FRAME_ID[7:0] + FRAME_ID[15:8]);

  typedef struct packed {
    logic signed [15:0] angle_now;
    logic signed [15:0] angle_target;
    logic signed [15:0] measured_torque;
    logic               enable;
    logic [15:0]        tick_count;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]         status_byte;
    logic [7:0]         torque_high;
    logic [7:0]         torque_low;
    logic [7:0]         spare_byte;
    logic [7:0]         checksum;
    logic signed [15:0] torque_value;
  } frame_item_t;

endpackage

// ===== design/strf_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type is a parameter; used with the types of strf_pkg.
`timescale 1ns / 1ps

interface strf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/steering_torque_ramp_frame_top.sv =====
// Steering torque ramp and five-byte command frame, top level.
// Depends on strf_pkg and strf_stream_if.
//
//   channel  direction  payload              transaction when
//   cmd      sink       strf_pkg::cmd_item_t   cmd.valid && cmd.ready
//   frame    source     strf_pkg::frame_item_t frame.valid && frame.ready
//   cfg      write      cfg_index, cfg_data    cfg_we
//
// A command accepted into the input register goes through the ramp logic while it sits
// there and moves into the output register, where its frame is offered, once that is free.
// One command is accepted per cycle unless a stalled frame keeps both registers full;
// the commanded torque register closes its loop, so successive commands see each other's
// result at once. A stalled frame holds the output register and the input register still
// takes one more command. Synchronous reset clears the torque and both valids and loads
// the configuration registers with their reset values.
`timescale 1ns / 1ps

module steering_torque_ramp_frame_top (
  input  logic                                 clk,
  input  logic                                 rst,
  strf_stream_if.sink                          cmd,
  strf_stream_if.source                        frame,
  input  logic                                 cfg_we,
  input  logic [strf_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [strf_pkg::CfgDataWidth-1:0]    cfg_data
);
  import strf_pkg::*;

  logic [5:0]         max_step;
  logic [11:0]        bound_margin;
  logic [12:0]        bound_limit;
  logic [11:0]        rate_window;
  logic signed [15:0] torque;

  cmd_item_t          s1;
  logic               s1_valid;
  logic               s1_advance;
  frame_item_t        frame_next;

  logic signed [18:0] meas_w, torque_start, upper, lower, diff, diff_abs;
  logic signed [18:0] ramped, clamp_hi, clamp_lo, clamped;
  logic [14:0]        step_raw;
  logic [5:0]         step;
  logic signed [15:0] torque_next;
  logic [17:0]        tick_x3;
  logic [5:0]         counter;
  logic [7:0]         status;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step     <= MAX_STEP_RESET;
      bound_margin <= BOUND_MARGIN_RESET;
      bound_limit  <= BOUND_LIMIT_RESET;
      rate_window  <= RATE_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_STEP:     max_step     <= cfg_data[5:0];
        REG_BOUND_MARGIN: bound_margin <= cfg_data[11:0];
        REG_BOUND_LIMIT:  bound_limit  <= cfg_data[12:0];
        REG_RATE_WINDOW:  rate_window  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign s1_advance = s1_valid && (!frame.valid || frame.ready);
  assign cmd.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1 <= cmd.data;
    end
  end

  // Ramp arithmetic in 19-bit signed, wide enough for every sum before saturation.
  always_comb begin
    meas_w       = {{3{s1.measured_torque[15]}}, s1.measured_torque};
    torque_start = s1.enable ? {{3{torque[15]}}, torque} : '0;
    upper = (meas_w + $signed({7'd0, bound_margin}) < $signed({6'd0, bound_limit}))
            ? meas_w + $signed({7'd0, bound_margin}) : $signed({6'd0, bound_limit});
    lower = (meas_w - $signed({7'd0, bound_margin}) > -$signed({6'd0, bound_limit}))
            ? meas_w - $signed({7'd0, bound_margin}) : -$signed({6'd0, bound_limit});
    diff     = torque_start - meas_w;
    diff_abs = diff[18] ? -diff : diff;
    step_raw = {1'b0, diff_abs[16:3]} + 15'd1;
    step     = (step_raw > {9'd0, max_step}) ? max_step : step_raw[5:0];

    if ((s1.angle_target > s1.angle_now) || (torque_start < lower)) begin
      ramped = torque_start + $signed({13'd0, step});
    end else if ((s1.angle_target < s1.angle_now) || (torque_start > upper)) begin
      ramped = torque_start - $signed({13'd0, step});
    end else begin
      ramped = torque_start;
    end

    clamp_hi = meas_w + $signed({7'd0, rate_window});
    clamp_lo = meas_w - $signed({7'd0, rate_window});
    clamped  = (ramped > clamp_hi) ? clamp_hi : ramped;
    clamped  = (clamped < clamp_lo) ? clamp_lo : clamped;

    if (clamped > 19'sd32767) begin
      torque_next = 16'sh7fff;
    end else if (clamped < -19'sd32768) begin
      torque_next = 16'sh8000;
    end else begin
      torque_next = clamped[15:0];
    end

    // Rolling counter: floor(3 * tick / 2) mod 64, plus one, wrapping in six bits.
    tick_x3 = {2'd0, s1.tick_count} + {1'b0, s1.tick_count, 1'b0};
    counter = tick_x3[6:1] + 6'd1;
    status  = {1'b1, counter, s1.enable};

    frame_next.status_byte  = status;
    frame_next.torque_high  = torque_next[15:8];
    frame_next.torque_low   = torque_next[7:0];
    frame_next.spare_byte   = 8'd0;
    frame_next.checksum     = CHECKSUM_SEED + status + torque_next[15:8] + torque_next[7:0];
    frame_next.torque_value = torque_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      torque      <= '0;
      frame.valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        torque <= torque_next;
      end
      if (s1_advance) begin
        frame.valid <= 1'b1;
      end else if (frame.ready) begin
        frame.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      frame.data <= frame_next;
    end
  end

  // The frame on show always carries the torque that the loop now holds.
  a_frame_matches_torque: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> frame.data.torque_value == torque)
    else $error("frame torque differs from commanded torque");

  a_checksum: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> frame.data.checksum == 8'(CHECKSUM_SEED + frame.data.status_byte
                                            + frame.data.torque_high
                                            + frame.data.torque_low))
    else $error("frame checksum inconsistent with frame bytes");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s1_valid && frame.valid && !frame.ready))
    else $error("command refused without a full pipeline");

  a_torque_moves_with_frame: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(torque))
    else $error("torque changed without a frame being produced");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!frame.valid && !s1_valid && torque == 16'sd0))
    else $error("pipeline not cleared by reset");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for steering_torque_ramp_frame_top.
// Depends on strf_pkg and strf_stream_if; predicts each command frame and checks it.
`timescale 1ns / 1ps

module testbench;
  import strf_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  strf_stream_if #(.payload_t(cmd_item_t))   cmd_ch ();
  strf_stream_if #(.payload_t(frame_item_t)) frame_ch ();

  steering_torque_ramp_frame_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .frame     (frame_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's registers and commanded torque.
  logic [5:0]  step_cap;
  logic [11:0] margin_r;
  logic [12:0] limit_r;
  logic [11:0] window_r;
  int          torque_now;

  frame_item_t frames_due[$];
  int items_sent;
  int frames_checked;
  int fail_count;
  int config_phases;

  // Idling controls for the command source and the receiver process.
  bit src_idle;
  bit sink_idle;
  int hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Works out the frame for one command and advances the torque shadow.
  function automatic frame_item_t ramp_and_pack(input cmd_item_t c);
    int t;
    int meas;
    int upper;
    int lower;
    int torque_gap;
    int step;
    logic [5:0]  ctr;
    logic [15:0] tq;
    frame_item_t f;
    meas  = int'(c.measured_torque);
    t     = c.enable ? torque_now : 0;
    upper = meas + int'(margin_r);
    if (upper > int'(limit_r)) upper = int'(limit_r);
    lower = meas - int'(margin_r);
    if (lower < -int'(limit_r)) lower = -int'(limit_r);
    torque_gap = t - meas;
    if (torque_gap < 0) torque_gap = -torque_gap;
    step = 1 + torque_gap / 8;
    if (step > int'(step_cap)) step = int'(step_cap);
    if (c.angle_target > c.angle_now || t < lower) begin
      t = t + step;
    end else if (c.angle_target < c.angle_now || t > upper) begin
      t = t - step;
    end
    if (t > meas + int'(window_r)) t = meas + int'(window_r);
    if (t < meas - int'(window_r)) t = meas - int'(window_r);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    torque_now = t;
    tq  = t[15:0];
    ctr = 6'((((3 * int'(c.tick_count)) / 2) % 64) + 1);
    f.status_byte  = {1'b1, ctr, c.enable};
    f.torque_high  = tq[15:8];
    f.torque_low   = tq[7:0];
    f.spare_byte   = 8'h00;
    f.checksum     = 8'(FRAME_LEN + FRAME_ID[7:0] + FRAME_ID[15:8] + f.status_byte
                        + f.torque_high + f.torque_low + f.spare_byte);
    f.torque_value = tq;
    return f;
  endfunction

  function automatic cmd_item_t make_cmd(input int curr, input int goal, input int meas,
                                         input bit en, input int tick);
    cmd_item_t c;
    c.angle_now       = 16'(curr);
    c.angle_target    = 16'(goal);
    c.measured_torque = 16'(meas);
    c.enable          = en;
    c.tick_count      = 16'(tick);
    return c;
  endfunction

  // Mostly keeps the measured torque near the commanded one so the bounds and
  // the window take effect; the rest spreads wider, partly over the full range.
  function automatic cmd_item_t random_cmd();
    int meas;
    int curr;
    int goal;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      meas = torque_now + int'($urandom_range(0, 1200)) - 600;
      if (meas > 32767) meas = 32767;
      if (meas < -32768) meas = -32768;
    end else if (pick < 8) begin
      meas = int'($urandom_range(0, 4000)) - 2000;
    end else begin
      meas = int'($signed(16'($urandom)));
    end
    curr = int'($signed(16'($urandom)));
    goal = ($urandom_range(0, 4) == 0) ? curr : int'($signed(16'($urandom)));
    return make_cmd(curr, goal, meas, $urandom_range(0, 9) != 0, int'($urandom_range(0, 65535)));
  endfunction

  task automatic send_cmd(input cmd_item_t it);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= it;
    do @(posedge clk); while (!cmd_ch.ready);
    frames_due.push_back(ramp_and_pack(it));
    items_sent++;
  endtask

  // Stops offering commands and waits for every outstanding frame, then lets
  // the pipeline settle before any register is touched.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; apply_config lowers it after the last write.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_MAX_STEP:     step_cap = val[5:0];
      REG_BOUND_MARGIN: margin_r = val[11:0];
      REG_BOUND_LIMIT:  limit_r  = val[12:0];
      REG_RATE_WINDOW:  window_r = val[11:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [12:0] ms, input logic [12:0] bm,
                              input logic [12:0] bl, input logic [12:0] rw);
    write_reg(REG_MAX_STEP, ms);
    write_reg(REG_BOUND_MARGIN, bm);
    write_reg(REG_BOUND_LIMIT, bl);
    write_reg(REG_RATE_WINDOW, rw);
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(0, 0, 0, 1'b0, 0));
    send_cmd(make_cmd(0, 100, 0, 1'b1, 1));
    send_cmd(make_cmd(100, 0, 0, 1'b1, 2));
    // Tick 42 gives a counter of 64, which wraps to zero.
    send_cmd(make_cmd(5, 5, 0, 1'b1, 42));
    send_cmd(make_cmd(0, 0, 32767, 1'b1, 16'hFFFF));
    send_cmd(make_cmd(0, 0, -32768, 1'b1, 16'h8000));
    send_cmd(make_cmd(-32768, 32767, 0, 1'b1, 16'h5555));
    send_cmd(make_cmd(32767, -32768, 0, 1'b1, 16'hAAAA));
    send_cmd(make_cmd(0, 0, 1000, 1'b1, 7));
    send_cmd(make_cmd(0, 0, -1000, 1'b0, 8));
    send_cmd(make_cmd(3, 3, 0, 1'b1, 9));
    wait_drained();
  endtask

  // Values wider than each register check that only the low bits are kept;
  // a max_step of zero leaves only the window clamp to move the torque.
  task automatic test_zero_step();
    apply_config(13'h0040, 13'h1000, 13'h0000, 13'h1064);
    send_cmd(make_cmd(0, 500, 50, 1'b1, 10));
    send_cmd(make_cmd(500, 0, -300, 1'b1, 11));
    send_cmd(make_cmd(0, 0, 400, 1'b1, 12));
    send_cmd(make_cmd(7, 7, 0, 1'b0, 13));
    wait_drained();
  endtask

  // A zero window pins the torque to the measured value at either extreme;
  // a wide window then lets one step push it past the 16-bit range.
  task automatic test_saturation();
    apply_config(13'd63, 13'd4095, 13'd8191, 13'd0);
    send_cmd(make_cmd(0, 0, 32767, 1'b1, 20));
    wait_drained();
    apply_config(13'd63, 13'd4095, 13'd8191, 13'd4095);
    send_cmd(make_cmd(0, 10, 32767, 1'b1, 21));
    send_cmd(make_cmd(0, 10, 32767, 1'b1, 22));
    wait_drained();
    apply_config(13'd63, 13'd4095, 13'd8191, 13'd0);
    send_cmd(make_cmd(0, 0, -32768, 1'b1, 23));
    wait_drained();
    apply_config(13'd63, 13'd4095, 13'd8191, 13'd4095);
    send_cmd(make_cmd(10, 0, -32768, 1'b1, 24));
    send_cmd(make_cmd(10, 0, -32768, 1'b1, 25));
    wait_drained();
  endtask

  // The receiver holds off long enough for both pipeline registers to fill
  // while commands keep coming, so the input must stall.
  task automatic test_backpressure();
    bit saved;
    saved = src_idle;
    apply_config(13'(MAX_STEP_RESET), 13'(BOUND_MARGIN_RESET), BOUND_LIMIT_RESET,
                 13'(RATE_WINDOW_RESET));
    src_idle = 1'b0;
    hold_req = 40;
    repeat (12) send_cmd(random_cmd());
    src_idle = saved;
    wait_drained();
  endtask

  task automatic run_random_phase(input int n_items, input logic [12:0] ms,
                                  input logic [12:0] bm, input logic [12:0] bl,
                                  input logic [12:0] rw);
    apply_config(ms, bm, bl, rw);
    repeat (n_items) send_cmd(random_cmd());
    wait_drained();
  endtask

  task automatic test_random();
    run_random_phase(100, 13'd1, 13'd0, 13'd0, 13'd0);
    run_random_phase(100, 13'd63, 13'd4095, 13'd8191, 13'd4095);
    run_random_phase(100, 13'(MAX_STEP_RESET), 13'(BOUND_MARGIN_RESET), BOUND_LIMIT_RESET,
                     13'(RATE_WINDOW_RESET));
    repeat (3) begin
      run_random_phase(100,
                       ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(1, 63)),
                       13'($urandom_range(0, ($urandom_range(0, 1) != 0) ? 600 : 8191)),
                       13'($urandom_range(0, ($urandom_range(0, 1) != 0) ? 2000 : 8191)),
                       13'($urandom_range(0, ($urandom_range(0, 1) != 0) ? 400 : 8191)));
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_random_phase(100, 13'($urandom_range(1, 63)), 13'($urandom_range(0, 4095)),
                     13'($urandom_range(0, 8191)), 13'($urandom_range(0, 4095)));
  endtask

  // Receiver: random stall bursts, plus a long hold-off when one is requested.
  initial begin
    int stall_left;
    stall_left = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        frame_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_req > 0) begin
        frame_ch.ready <= 1'b0;
        stall_left = hold_req - 1;
        hold_req = 0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        frame_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  // Frame checker.
  initial begin
    frame_item_t got;
    frame_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && frame_ch.valid && frame_ch.ready) begin
        got = frame_ch.data;
        if (frames_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected frame: st=%h hi=%h lo=%h sp=%h ck=%h tq=%0d",
                     got.status_byte, got.torque_high, got.torque_low, got.spare_byte,
                     got.checksum, got.torque_value);
          end
        end else begin
          want = frames_due.pop_front();
          if (got.status_byte !== want.status_byte || got.torque_high !== want.torque_high ||
              got.torque_low !== want.torque_low || got.spare_byte !== want.spare_byte ||
              got.checksum !== want.checksum || got.torque_value !== want.torque_value) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("frame %0d mismatch: expected st=%h hi=%h lo=%h sp=%h ck=%h tq=%0d",
                       frames_checked, want.status_byte, want.torque_high, want.torque_low,
                       want.spare_byte, want.checksum, want.torque_value);
              $display("                   actual   st=%h hi=%h lo=%h sp=%h ck=%h tq=%0d",
                       got.status_byte, got.torque_high, got.torque_low, got.spare_byte,
                       got.checksum, got.torque_value);
            end
          end
        end
        frames_checked++;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_MAX_STEP;
    cfg_data     <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    step_cap      = MAX_STEP_RESET;
    margin_r      = BOUND_MARGIN_RESET;
    limit_r       = BOUND_LIMIT_RESET;
    window_r      = RATE_WINDOW_RESET;
    torque_now    = 0;
    items_sent    = 0;
    frames_checked = 0;
    fail_count    = 0;
    config_phases = 0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    hold_req      = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_zero_step();
    test_saturation();
    test_backpressure();
    test_random();
    test_full_rate();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("run covered %0d commands and %0d frames over %0d register settings,",
             items_sent, frames_checked, config_phases);
    $display("including saturation, counter wrap, zero step and a long output stall");
    if (fail_count == 0 && frames_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
